// ----- hw/rtl/dda3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dda3_pkg: shared types and constants for the three-axis DDA step generator
// Holds the axis count and the input word action codes.
// ----------------------------------------------------------------------------
package dda3_pkg;

  localparam int unsigned NumAxes = 3;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

endpackage : dda3_pkg
`default_nettype wire

// ----- hw/rtl/three_axis_dda_step_generator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_dda_step_generator_core: x/y/z DDA line interpolator
// A load word sets start and goal positions for a straight move. Each tick
// word advances the error counters and reports which axes step, honoring
// min/max endstops (optionally active low via the switch_invert register).
//
// Channels: input words on in_valid_i/in_ready_o, one result word per input
// word on out_valid_o/out_ready_i. A word is moved when valid and ready are
// both high at a rising edge.
// Result: the result of a word appears in the cycle after it is accepted.
// Throughput: one word per cycle unless stalled; the per-axis add, compare
// and subtract on the error counter sits between the input ports and the
// state/result registers, so a tick can follow the previous one next cycle.
// Stall: the result register holds while out_ready_i is low; in_ready_o
// stays high as long as the result register is empty or being drained.
// Reset: positions, goals, deltas and counters clear, directions go to 1
// (toward larger), switch_invert clears and no result is pending.
// Configuration: cfg_we_i writes cfg_wdata_i into switch_invert at once.
// ----------------------------------------------------------------------------
module three_axis_dda_step_generator_core #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // configuration
  input  wire                cfg_we_i,
  input  wire                cfg_wdata_i,
  // input words
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                action_i,
  input  wire signed [31:0]  start_x_i,
  input  wire signed [31:0]  start_y_i,
  input  wire signed [31:0]  start_z_i,
  input  wire signed [31:0]  goal_x_i,
  input  wire signed [31:0]  goal_y_i,
  input  wire signed [31:0]  goal_z_i,
  input  wire        [2:0]   min_switches_i,
  input  wire        [2:0]   max_switches_i,
  // result words
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic       [2:0]   step_pulses_o,
  output logic       [2:0]   directions_o,
  output logic               move_active_o,
  output logic signed [31:0] now_x_o,
  output logic signed [31:0] now_y_o,
  output logic signed [31:0] now_z_o
);

  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned DW = POS_WIDTH + 1;
  localparam int unsigned EW = POS_WIDTH + 2;
  localparam int unsigned NA = dda3_pkg::NumAxes;

  // per-axis move state
  logic signed [PW-1:0] pos_q  [NA];
  logic signed [PW-1:0] pos_d  [NA];
  logic signed [PW-1:0] goal_q [NA];
  logic signed [PW-1:0] goal_d [NA];
  logic        [DW-1:0] delta_q [NA];
  logic        [DW-1:0] delta_d [NA];
  logic signed [EW-1:0] err_q  [NA];
  logic signed [EW-1:0] err_d  [NA];
  logic        [NA-1:0] dir_q, dir_d;
  logic        [DW-1:0] largest_q, largest_d;
  logic                 invert_q;

  // result register
  logic                 out_valid_q;
  logic        [NA-1:0] pulses_q, pulses_d;
  logic                 active_q, active_d;

  // combinational helpers
  logic signed [PW-1:0] ld_start [NA];
  logic signed [PW-1:0] ld_goal  [NA];
  logic signed [DW-1:0] ld_diff  [NA];
  logic        [DW-1:0] ld_delta [NA];
  logic signed [EW-1:0] tk_sum   [NA];
  logic        [NA-1:0] mins, maxs, axis_free;

  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ld_start[0] = PW'(start_x_i);
  assign ld_start[1] = PW'(start_y_i);
  assign ld_start[2] = PW'(start_z_i);
  assign ld_goal[0]  = PW'(goal_x_i);
  assign ld_goal[1]  = PW'(goal_y_i);
  assign ld_goal[2]  = PW'(goal_z_i);

  assign mins = min_switches_i ^ {NA{invert_q}};
  assign maxs = max_switches_i ^ {NA{invert_q}};

  always_comb begin
    largest_d = largest_q;
    dir_d     = dir_q;
    pulses_d  = '0;
    active_d  = 1'b0;
    axis_free = '0;
    for (int i = 0; i < NA; i++) begin
      pos_d[i]    = pos_q[i];
      goal_d[i]   = goal_q[i];
      delta_d[i]  = delta_q[i];
      err_d[i]    = err_q[i];
      ld_diff[i]  = DW'(ld_goal[i]) - DW'(ld_start[i]);
      ld_delta[i] = ld_diff[i][DW-1] ? DW'(-ld_diff[i]) : DW'(ld_diff[i]);
      tk_sum[i]   = err_q[i] + EW'(delta_q[i]);
    end

    if (dda3_pkg::action_e'(action_i) == dda3_pkg::ACT_LOAD) begin
      largest_d = ld_delta[0];
      if (ld_delta[1] > largest_d) largest_d = ld_delta[1];
      if (ld_delta[2] > largest_d) largest_d = ld_delta[2];
      for (int i = 0; i < NA; i++) begin
        pos_d[i]   = ld_start[i];
        goal_d[i]  = ld_goal[i];
        dir_d[i]   = !ld_diff[i][DW-1];
        delta_d[i] = ld_delta[i];
        err_d[i]   = -EW'(largest_d >> 1);
      end
    end else begin
      for (int i = 0; i < NA; i++) begin
        // block an axis that sits on its goal or pushes into its active endstop
        axis_free[i] = (pos_q[i] != goal_q[i])
                       && !(mins[i] && !dir_q[i])
                       && !(maxs[i] && dir_q[i]);
        if (axis_free[i]) begin
          err_d[i] = tk_sum[i];
          if (!tk_sum[i][EW-1] && (tk_sum[i] != '0)) begin
            err_d[i]    = tk_sum[i] - EW'(largest_q);
            pulses_d[i] = 1'b1;
            pos_d[i]    = dir_q[i] ? pos_q[i] + PW'(1) : pos_q[i] - PW'(1);
          end
        end
      end
      active_d = |axis_free;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= 1'b0;
      dir_q     <= '1;
      largest_q <= '0;
      for (int i = 0; i < NA; i++) begin
        pos_q[i]   <= '0;
        goal_q[i]  <= '0;
        delta_q[i] <= '0;
        err_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        dir_q     <= dir_d;
        largest_q <= largest_d;
        for (int i = 0; i < NA; i++) begin
          pos_q[i]   <= pos_d[i];
          goal_q[i]  <= goal_d[i];
          delta_q[i] <= delta_d[i];
          err_q[i]   <= err_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pulses_q <= pulses_d;
      active_q <= active_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign step_pulses_o = pulses_q;
  assign move_active_o = active_q;
  assign directions_o  = dir_q;
  assign now_x_o       = 32'(pos_q[0]);
  assign now_y_o       = 32'(pos_q[1]);
  assign now_z_o       = 32'(pos_q[2]);

  // a load word never reports steps or activity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (action_i == dda3_pkg::ACT_LOAD))
      |=> (out_valid_o && (step_pulses_o == '0) && !move_active_o))
    else $error("load result shows steps or activity");

  // any step implies the move was active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (step_pulses_o != '0)) |-> move_active_o)
    else $error("step pulse without active move");

  // the x axis on its goal never steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (action_i == dda3_pkg::ACT_TICK) && (pos_q[0] == goal_q[0]))
      |=> !step_pulses_o[0])
    else $error("x stepped while on goal");

  // a stalled result keeps its positions and directions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i)
      |=> ($stable(now_x_o) && $stable(now_y_o) && $stable(now_z_o)
           && $stable(directions_o)))
    else $error("state changed while result stalled");

endmodule : three_axis_dda_step_generator_core
`default_nettype wire
